>>> rtl/bdec_pkg.sv
package bdec_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 2;
  localparam int FLAG_W         = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_MODE     = 2'd1,
    REG_POLARITY = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CNT_BOTH    = 2'd0,
    CNT_PRESS   = 2'd1,
    CNT_RELEASE = 2'd2
  } count_mode_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  localparam logic [1:0] MODE_RESET     = CNT_PRESS;
  localparam logic       POLARITY_RESET = 1'b1;
  // released level for the reset polarity (active low -> high is released)
  localparam logic       LEVEL_RESET    = 1'b1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [1:0]            count_mode;
    logic                  active_low;
  } cfg_t;

  // steady_level sits in the lowest bit
  typedef struct packed {
    logic changed;
    logic released;
    logic pressed;
    logic is_on;
    logic steady_level;
  } flags_t;

endpackage

>>> rtl/bdec_cfg.sv
module bdec_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bdec_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bdec_pkg::cfg_t                     cfg
);

  bdec_pkg::cfg_t cfg_r;
  bdec_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bdec_pkg::REG_DEBOUNCE: cfg_nxt.debounce_ms = cfg_wdata;
        bdec_pkg::REG_MODE:     cfg_nxt.count_mode  = cfg_wdata[1:0];
        bdec_pkg::REG_POLARITY: cfg_nxt.active_low  = cfg_wdata[0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= '0;
      cfg_r.count_mode  <= bdec_pkg::MODE_RESET;
      cfg_r.active_low  <= bdec_pkg::POLARITY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bdec_core.sv
module bdec_core #(
  parameter int TIME_BITS  = bdec_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bdec_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  op,
  input  logic                  pin_level,
  input  logic [TIME_BITS-1:0]  now_ms,
  input  bdec_pkg::cfg_t        cfg,
  output bdec_pkg::flags_t      flags,
  output logic [COUNT_BITS-1:0] edge_count
);

  localparam int CMP_BITS = (TIME_BITS > bdec_pkg::CFG_DATA_W) ?
                            TIME_BITS : bdec_pkg::CFG_DATA_W;

  logic                  raw_last_r,    raw_last_nxt;
  logic [TIME_BITS-1:0]  change_time_r, change_time_nxt;
  logic                  steady_r,      steady_nxt;
  logic [COUNT_BITS-1:0] edge_total_r,  edge_total_nxt;

  logic                 on_level;
  logic [TIME_BITS-1:0] elapsed;
  logic                 held;
  logic                 chg;
  logic                 prs;
  logic                 rel;
  logic                 cnt;

  always_comb begin
    on_level        = ~cfg.active_low;
    raw_last_nxt    = raw_last_r;
    change_time_nxt = change_time_r;
    steady_nxt      = steady_r;
    edge_total_nxt  = edge_total_r;
    elapsed         = '0;
    held            = 1'b0;
    chg             = 1'b0;
    prs             = 1'b0;
    rel             = 1'b0;
    cnt             = 1'b0;
    if (op == bdec_pkg::OP_CLEAR) begin
      edge_total_nxt = '0;
    end else begin
      if (pin_level != raw_last_r) begin
        change_time_nxt = now_ms;
        raw_last_nxt    = pin_level;
      end
      elapsed = now_ms - change_time_nxt;
      held    = CMP_BITS'(elapsed) >= CMP_BITS'(cfg.debounce_ms);
      if (held) begin
        steady_nxt = pin_level;
        chg        = steady_r != pin_level;
        prs        = chg && (pin_level == on_level);
        rel        = chg && (pin_level != on_level);
        unique case (cfg.count_mode)
          bdec_pkg::CNT_BOTH:    cnt = chg;
          bdec_pkg::CNT_PRESS:   cnt = prs;
          bdec_pkg::CNT_RELEASE: cnt = rel;
          default:               cnt = 1'b0;
        endcase
        if (cnt) begin
          edge_total_nxt = edge_total_r + COUNT_BITS'(1);
        end
      end
    end
    flags.steady_level = steady_nxt;
    flags.is_on        = steady_nxt == on_level;
    flags.pressed      = prs;
    flags.released     = rel;
    flags.changed      = chg;
    edge_count         = edge_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_last_r    <= bdec_pkg::LEVEL_RESET;
      change_time_r <= '0;
      steady_r      <= bdec_pkg::LEVEL_RESET;
      edge_total_r  <= '0;
    end else if (step) begin
      raw_last_r    <= raw_last_nxt;
      change_time_r <= change_time_nxt;
      steady_r      <= steady_nxt;
      edge_total_r  <= edge_total_nxt;
    end
  end

endmodule

>>> rtl/button_debounce_edge_counter_unit.sv
// Button debouncer with steady-edge counter.
// Input stream: in_tuser is the op (0 sample, 1 clear count); in_tdata holds
// the raw pin level and the millisecond timestamp. Each request yields exactly
// one result on the output stream: steady level, is_on, pressed, released,
// changed flags and the running edge count.
// A request is captured in an input register, evaluated against the debounce
// state by one subtract-and-compare pass and written to the output register,
// which drives out_tvalid; one request per cycle is sustained as long as
// the receiver takes results.
// When out_tready is low, the output register holds its result and the input
// register holds one more request; in_tready drops only when both are full.
// Synchronous reset (rst_n low) empties both registers, restores the
// registers to debounce 0 ms, press counting, active-low polarity, and sets
// raw and steady levels to the released level with timer and count at zero.
// Configuration writes take effect at once and are meant for idle periods.
module button_debounce_edge_counter_unit #(
  parameter int TIME_BITS  = bdec_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = bdec_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // pin_level, now_ms, zero pad
  input  logic [((1+TIME_BITS+7)/8)*8-1:0]      in_tdata,
  // op
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // steady_level, is_on, pressed, released, changed, edge_count, zero pad
  output logic [((bdec_pkg::FLAG_W+COUNT_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                                  cfg_we,
  input  logic [bdec_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bdec_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int OUT_W = ((bdec_pkg::FLAG_W + COUNT_BITS + 7) / 8) * 8;

  bdec_pkg::cfg_t cfg;

  logic                  in_vld_r;
  logic                  op_r;
  logic                  pin_r;
  logic [TIME_BITS-1:0]  now_r;
  logic                  out_vld_r;
  bdec_pkg::flags_t      flags_r;
  logic [COUNT_BITS-1:0] count_r;

  logic                  step;
  bdec_pkg::flags_t      flags;
  logic [COUNT_BITS-1:0] edge_count;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  bdec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdec_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .op         (op_r),
    .pin_level  (pin_r),
    .now_ms     (now_r),
    .cfg        (cfg),
    .flags      (flags),
    .edge_count (edge_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r  <= in_tuser;
      pin_r <= in_tdata[0];
      now_r <= in_tdata[TIME_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      flags_r <= flags;
      count_r <= edge_count;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({count_r, flags_r});

endmodule
